FILE: rtl/rstpc_pkg.sv
// ----------------------------------------------------------------------------
// rstpc_pkg
// Shared widths, codes and types for the RST polynomial controller.
// ----------------------------------------------------------------------------
package rstpc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 24;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int ORDER_W  = 7;
	localparam int SEL_W    = 2;
	localparam int CIDX_W   = 6;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_LOAD   = 1'b1;

	typedef enum logic [SEL_W-1:0] {
		SEL_R = 2'd0,
		SEL_S = 2'd1,
		SEL_T = 2'd2
	} coef_sel_t;

	typedef struct packed {
		logic clear;
		logic en;
		logic sub;
	} mac_ctl_t;

endpackage

FILE: rtl/rstpc_req_if.sv
// ----------------------------------------------------------------------------
// rstpc_req_if
// Request channel: control samples and coefficient loads.
// ----------------------------------------------------------------------------
interface rstpc_req_if;
	import rstpc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic signed [SAMPLE_W-1:0] measurement;
	logic signed [SAMPLE_W-1:0] reference;
	logic        [SEL_W-1:0]    coef_select;
	logic        [CIDX_W-1:0]   coef_index;
	logic signed [COEF_W-1:0]   coef_value;

	modport source (
		output valid, req_type, measurement, reference, coef_select, coef_index, coef_value,
		input  ready
	);

	modport sink (
		input  valid, req_type, measurement, reference, coef_select, coef_index, coef_value,
		output ready
	);

endinterface

FILE: rtl/rstpc_rsp_if.sv
// ----------------------------------------------------------------------------
// rstpc_rsp_if
// Result channel: saturated control value and saturation flag.
// ----------------------------------------------------------------------------
interface rstpc_rsp_if;
	import rstpc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] control_value;
	logic                       saturated;

	modport source (
		output valid, control_value, saturated,
		input  ready
	);

	modport sink (
		input  valid, control_value, saturated,
		output ready
	);

endinterface

FILE: rtl/rstpc_mem.sv
// ----------------------------------------------------------------------------
// rstpc_mem
// One write / one read memory with registered read and per-entry valid
// bits; an entry never written reads as zero.
// ----------------------------------------------------------------------------
module rstpc_mem #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	import rstpc_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			if (re)
				rd_vld_q <= vld_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rd_q <= mem_q[raddr];
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

FILE: rtl/rstpc_mac.sv
// ----------------------------------------------------------------------------
// rstpc_mac
// Shared multiply-accumulate: registered product, then add or subtract
// into a wide accumulator.
// ----------------------------------------------------------------------------
module rstpc_mac #(
	parameter int ACC_W = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rstpc_pkg::mac_ctl_t                  ctl,
	input  logic signed [rstpc_pkg::COEF_W-1:0]   coef,
	input  logic signed [rstpc_pkg::SAMPLE_W-1:0] samp,
	output logic signed [ACC_W-1:0]              acc
);
	import rstpc_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     en_s1;
	logic                     sub_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_x;

	always_ff @(posedge clk) begin
		prod_s1 <= coef * samp;
	end

	assign prod_x = ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1  <= 1'b0;
			sub_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			en_s1  <= ctl.en;
			sub_s1 <= ctl.sub;
			if (ctl.clear)
				acc_q <= '0;
			else if (en_s1)
				acc_q <= sub_s1 ? (acc_q - prod_x) : (acc_q + prod_x);
		end
	end

	assign acc = acc_q;

endmodule

FILE: rtl/rst_polynomial_controller.sv
// ----------------------------------------------------------------------------
// rst_polynomial_controller
// Fixed-point RST controller: u = sum T*ref - sum R*meas - sum S*u_past,
// rounded, saturated to 16 bits and fed back into the output history.
// ----------------------------------------------------------------------------
//  channel  dir  beat content
//  req      in   req_type, measurement, reference, coef_select/index/value
//  rsp      out  control_value, saturated
//  cfg      in   cfg_we / cfg_wdata -> order_in_use
//
//  A coefficient load leaves req ready. For a control sample, one shared
//  multiplier does three products per tap in use while the history lines
//  shift through one memory port. Reset clears histories and coefficients
//  at once through valid bits. req is not ready while a sample is in work;
//  a result waiting on rsp holds the next sample at its final cycle only.
// ----------------------------------------------------------------------------
module rst_polynomial_controller #(
	parameter int MAX_ORDER      = 64,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rstpc_pkg::ORDER_W-1:0]  cfg_wdata,
	rstpc_req_if.sink                      req,
	rstpc_rsp_if.source                    rsp
);
	import rstpc_pkg::*;

	localparam int IDX_W = $clog2(MAX_ORDER);
	localparam int CMP_W = ((IDX_W > CIDX_W) ? IDX_W : CIDX_W) + 1;
	localparam int CNT_W = ((IDX_W + 1) > ORDER_W) ? (IDX_W + 1) : ORDER_W;
	localparam int ACC_W = PROD_W + $clog2(3 * MAX_ORDER) + 1;

	localparam logic [1:0] PH_RD = 2'd0;
	localparam logic [1:0] PH_T  = 2'd1;
	localparam logic [1:0] PH_R  = 2'd2;

	localparam logic signed [ACC_W:0] HALF = (ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W:0] SMAX = (ACC_W + 1)'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [ACC_W:0] SMIN = (ACC_W + 1)'(-(2 ** (SAMPLE_W - 1)));

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

	state_t                     state_q;
	logic [1:0]                 ph_q;
	logic [IDX_W-1:0]           k_q;
	logic                       first_q;
	logic [ORDER_W-1:0]         order_q;
	logic signed [SAMPLE_W-1:0] meas_q;
	logic signed [SAMPLE_W-1:0] ref_q;
	logic                       rsp_vld_q;
	logic signed [SAMPLE_W-1:0] ctrl_q;
	logic                       sat_q;

	logic                   req_fire, smp_fire, ld_fire;
	logic [CMP_W-1:0]       idx_ext;
	logic                   idx_ok;
	logic [IDX_W-1:0]       ld_addr;
	logic                   r_we, s_we, t_we;
	logic [CNT_W-1:0]       order_ext;
	logic [CNT_W-1:0]       k_start_x;
	logic [IDX_W-1:0]       k_start;

	logic                   coef_re, hist_re, hist_we, out_we, fin_go;
	logic [IDX_W-1:0]       hist_raddr, out_waddr;
	logic [SAMPLE_W-1:0]    meas_rd, ref_rd, out_rd;
	logic [SAMPLE_W-1:0]    meas_wd, ref_wd, out_wd;
	logic [COEF_W-1:0]      r_rd, s_rd, t_rd;

	mac_ctl_t                   mctl;
	logic signed [COEF_W-1:0]   mcoef;
	logic signed [SAMPLE_W-1:0] msamp;
	logic signed [ACC_W-1:0]    acc;

	logic signed [ACC_W:0]      rnd, shv;
	logic                       sat_hi, sat_lo;
	logic signed [SAMPLE_W-1:0] r_val;

	// request decode
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign smp_fire  = req_fire && (req.req_type == REQ_SAMPLE);
	assign ld_fire   = req_fire && (req.req_type == REQ_LOAD);

	assign idx_ext = CMP_W'(req.coef_index);
	assign idx_ok  = idx_ext < CMP_W'(MAX_ORDER);
	assign ld_addr = idx_ext[IDX_W-1:0];
	assign r_we    = ld_fire && idx_ok && (req.coef_select == SEL_R);
	assign s_we    = ld_fire && idx_ok && (req.coef_select == SEL_S);
	assign t_we    = ld_fire && idx_ok && (req.coef_select == SEL_T);

	// taps in use, clamped to 1..MAX_ORDER, minus one
	assign order_ext = CNT_W'(order_q);
	always_comb begin
		priority if (order_ext == '0)
			k_start_x = '0;
		else if (order_ext > CNT_W'(MAX_ORDER))
			k_start_x = CNT_W'(MAX_ORDER - 1);
		else
			k_start_x = order_ext - CNT_W'(1);
	end
	assign k_start = k_start_x[IDX_W-1:0];

	// memory ports; taps are walked from the top down so the shift is in place
	assign coef_re    = (state_q == ST_RUN) && (ph_q == PH_RD);
	assign hist_re    = coef_re && (k_q != '0);
	assign hist_raddr = k_q - IDX_W'(1);
	assign hist_we    = (state_q == ST_RUN) && (ph_q == PH_T);
	assign fin_go     = (state_q == ST_FIN) && (!rsp_vld_q || rsp.ready);
	assign out_we     = (hist_we && (k_q != '0)) || fin_go;
	assign out_waddr  = fin_go ? '0 : k_q;
	assign out_wd     = fin_go ? r_val : out_rd;
	assign meas_wd    = (k_q == '0) ? meas_q : meas_rd;
	assign ref_wd     = (k_q == '0) ? ref_q : ref_rd;

	rstpc_mem #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ORDER)) u_meas_mem (
		.clk, .arst_n, .we(hist_we), .waddr(k_q), .wdata(meas_wd),
		.re(hist_re), .raddr(hist_raddr), .rdata(meas_rd)
	);

	rstpc_mem #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ORDER)) u_ref_mem (
		.clk, .arst_n, .we(hist_we), .waddr(k_q), .wdata(ref_wd),
		.re(hist_re), .raddr(hist_raddr), .rdata(ref_rd)
	);

	rstpc_mem #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ORDER)) u_out_mem (
		.clk, .arst_n, .we(out_we), .waddr(out_waddr), .wdata(out_wd),
		.re(hist_re), .raddr(hist_raddr), .rdata(out_rd)
	);

	rstpc_mem #(.WIDTH(COEF_W), .DEPTH(MAX_ORDER)) u_r_mem (
		.clk, .arst_n, .we(r_we), .waddr(ld_addr), .wdata(req.coef_value),
		.re(coef_re), .raddr(k_q), .rdata(r_rd)
	);

	rstpc_mem #(.WIDTH(COEF_W), .DEPTH(MAX_ORDER)) u_s_mem (
		.clk, .arst_n, .we(s_we), .waddr(ld_addr), .wdata(req.coef_value),
		.re(coef_re), .raddr(k_q), .rdata(s_rd)
	);

	rstpc_mem #(.WIDTH(COEF_W), .DEPTH(MAX_ORDER)) u_t_mem (
		.clk, .arst_n, .we(t_we), .waddr(ld_addr), .wdata(req.coef_value),
		.re(coef_re), .raddr(k_q), .rdata(t_rd)
	);

	// operand select: read phase also multiplies the S term of the tap above
	always_comb begin
		mctl       = '0;
		mcoef      = '0;
		msamp      = '0;
		mctl.clear = smp_fire;
		if (state_q == ST_RUN) begin
			unique case (ph_q)
				PH_RD: begin
					mctl.en  = !first_q;
					mctl.sub = 1'b1;
					mcoef    = $signed(s_rd);
					msamp    = $signed(out_rd);
				end
				PH_T: begin
					mctl.en = 1'b1;
					mcoef   = $signed(t_rd);
					msamp   = (k_q == '0) ? ref_q : $signed(ref_rd);
				end
				PH_R: begin
					mctl.en  = 1'b1;
					mctl.sub = 1'b1;
					mcoef    = $signed(r_rd);
					msamp    = (k_q == '0) ? meas_q : $signed(meas_rd);
				end
				default: ;
			endcase
		end
	end

	rstpc_mac #(.ACC_W(ACC_W)) u_mac (
		.clk, .arst_n, .ctl(mctl), .coef(mcoef), .samp(msamp), .acc
	);

	// round half up, then clamp
	assign rnd    = (ACC_W + 1)'(acc) + HALF;
	assign shv    = rnd >>> COEF_FRAC_BITS;
	assign sat_hi = shv > SMAX;
	assign sat_lo = shv < SMIN;
	always_comb begin
		priority if (sat_hi)
			r_val = SMAX[SAMPLE_W-1:0];
		else if (sat_lo)
			r_val = SMIN[SAMPLE_W-1:0];
		else
			r_val = shv[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ph_q      <= PH_RD;
			k_q       <= '0;
			first_q   <= 1'b0;
			order_q   <= ORDER_W'(1);
			rsp_vld_q <= 1'b0;
		end else begin
			if (cfg_we)
				order_q <= cfg_wdata;
			if (rsp_vld_q && rsp.ready && !fin_go)
				rsp_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (smp_fire) begin
						state_q <= ST_RUN;
						ph_q    <= PH_RD;
						k_q     <= k_start;
						first_q <= 1'b1;
					end
				end
				ST_RUN: begin
					unique case (ph_q)
						PH_RD:   ph_q <= PH_T;
						PH_T:    ph_q <= PH_R;
						default: begin
							ph_q    <= PH_RD;
							first_q <= 1'b0;
							if (k_q == '0)
								state_q <= ST_DRAIN;
							else
								k_q <= k_q - IDX_W'(1);
						end
					endcase
				end
				ST_DRAIN: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						rsp_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (smp_fire) begin
			meas_q <= req.measurement;
			ref_q  <= req.reference;
		end
		if (fin_go) begin
			ctrl_q <= r_val;
			sat_q  <= sat_hi || sat_lo;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.control_value = ctrl_q;
	assign rsp.saturated     = sat_q;

`ifndef SYNTHESIS
	a_smp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		smp_fire |=> !req.ready)
		else $error("sample accepted but request side still ready");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		ld_fire |=> req.ready)
		else $error("coefficient load did not return to idle");

	a_phase_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> (ph_q == PH_RD))
		else $error("tap phase left mid-sequence");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside final state");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.saturated) |->
			(rsp.control_value == SMAX[SAMPLE_W-1:0] ||
			 rsp.control_value == SMIN[SAMPLE_W-1:0]))
		else $error("saturation flag without clamped value");
`endif

endmodule
